/* rtl/core/kct_pkg.sv */
`timescale 1ns / 1ps
package kct_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int COUNT_BITS    = 32;
  localparam int ID_BITS       = 31;
  localparam int OUT_CNT_BITS  = 32;
  localparam int REQ_BITS      = 2;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  localparam logic [REQ_BITS-1:0] REQ_INC   = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_DEC   = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_QUERY = 2'd2;
  // unused code, dropped without a result
  localparam logic [REQ_BITS-1:0] REQ_RSVD  = 2'd3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_MAX,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // one table entry as held in a cell
  typedef struct packed {
    logic                  valid;
    logic [ID_BITS-1:0]    id;
    logic [COUNT_BITS-1:0] count;
  } slot_t;

  // command broadcast to every cell
  typedef struct packed {
    logic               rotate;
    logic               inc;
    logic               dec;
    logic [ID_BITS-1:0] id;
  } cell_cmd_t;

endpackage

/* rtl/core/kct_if.sv */
`timescale 1ns / 1ps
interface kct_in_if;
  logic                         valid;
  logic                         ready;
  logic [kct_pkg::REQ_BITS-1:0] req_type;
  logic [kct_pkg::ID_BITS-1:0]  content_id;

  modport source (output valid, output req_type, output content_id, input ready);
  modport sink   (input valid, input req_type, input content_id, output ready);
endinterface

interface kct_out_if;
  logic                             valid;
  logic                             ready;
  logic [kct_pkg::ID_BITS-1:0]      top_id;
  logic [kct_pkg::OUT_CNT_BITS-1:0] top_count;
  logic                             table_empty;
  logic                             overflow_seen;
  logic                             last;

  modport source (output valid, output top_id, output top_count, output table_empty,
                  output overflow_seen, output last, input ready);
  modport sink   (input valid, input top_id, input top_count, input table_empty,
                  input overflow_seen, input last, output ready);
endinterface

/* rtl/core/kct_cell.sv */
`timescale 1ns / 1ps
module kct_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  kct_pkg::cell_cmd_t cmd,
  input  logic               ins_en,
  input  kct_pkg::slot_t     nb_slot,
  output kct_pkg::slot_t     slot,
  output logic               hit
);

  logic                           valid_r, valid_nxt;
  logic [kct_pkg::ID_BITS-1:0]    id_r, id_nxt;
  logic [kct_pkg::COUNT_BITS-1:0] count_r, count_nxt;

  assign hit  = valid_r && (id_r == cmd.id);
  assign slot = '{valid: valid_r, id: id_r, count: count_r};

  // rotate, update on match, or take a new id
  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    count_nxt = count_r;
    if (cmd.rotate) begin
      valid_nxt = nb_slot.valid;
      id_nxt    = nb_slot.id;
      count_nxt = nb_slot.count;
    end else if (cmd.inc && hit) begin
      if (count_r != kct_pkg::COUNT_MAX) begin
        count_nxt = count_r + kct_pkg::COUNT_BITS'(1);
      end
    end else if (cmd.dec && hit) begin
      if (count_r <= kct_pkg::COUNT_BITS'(1)) begin
        valid_nxt = 1'b0;
      end else begin
        count_nxt = count_r - kct_pkg::COUNT_BITS'(1);
      end
    end else if (ins_en) begin
      valid_nxt = 1'b1;
      id_nxt    = cmd.id;
      count_nxt = kct_pkg::COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    count_r <= count_nxt;
  end

endmodule

/* rtl/core/keyed_counter_table_max_ties_top.sv */
`timescale 1ns / 1ps
// Keyed counter table with a highest-count query.
// in_ch carries requests: req_type 0 increments content_id, 1 decrements it,
// 2 queries the ids that hold the highest count. Updates of id 0 and code 3 are dropped.
// out_ch carries query results in ascending id order, last set on the final
// one; an empty table gives one result with table_empty set.
// An update is accepted, then applied in every cell, and gives no result.
// The entries sit in a ring of cells; a query rotates the ring once to find
// the highest count, then once more per result, and hands each result over
// before the next pass. in_ch.ready is low during a query.
// A result waits in the output register while out_ch.ready is low; the next
// pass starts when it has been taken.
// Reset (rst_n low, synchronous) empties the table and clears the overflow
// flag at once; no clearing pass is needed.
module keyed_counter_table_max_ties_top (
  input  logic      clk,
  input  logic      rst_n,
  kct_in_if.sink    in_ch,
  kct_out_if.source out_ch
);

  localparam int N = kct_pkg::TABLE_ENTRIES;

  kct_pkg::state_t                state_r, state_nxt;
  logic [kct_pkg::REQ_BITS-1:0]   req_type_r, req_type_nxt;
  logic [kct_pkg::ID_BITS-1:0]    req_id_r, req_id_nxt;
  logic [kct_pkg::IDX_W-1:0]      step_r, step_nxt;
  logic [kct_pkg::COUNT_BITS-1:0] best_r, best_nxt;
  logic                           any_r, any_nxt;
  logic [kct_pkg::ID_BITS-1:0]    prev_r, prev_nxt;
  logic [kct_pkg::ID_BITS-1:0]    next_r, next_nxt;
  logic                           got_r, got_nxt;
  logic                           more_r, more_nxt;
  logic                           dropped_r, dropped_nxt;
  logic [kct_pkg::ID_BITS-1:0]    o_id_r, o_id_nxt;
  logic [kct_pkg::COUNT_BITS-1:0] o_count_r, o_count_nxt;
  logic                           o_empty_r, o_empty_nxt;
  logic                           o_last_r, o_last_nxt;

  kct_pkg::cell_cmd_t cmd;
  kct_pkg::slot_t     slots [N];
  logic [N-1:0]       hit_vec;
  logic [N-1:0]       free_vec;
  logic [N-1:0]       ins_vec;
  logic               any_hit;
  logic               do_ins;
  logic               in_acc;
  logic               pass_end;
  logic               cand;
  kct_pkg::slot_t     scan;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign pass_end = (step_r == kct_pkg::IDX_W'(N - 1));
  assign scan     = slots[0];
  assign any_hit  = |hit_vec;

  // pick the lowest free cell for an insert
  assign do_ins  = (state_r == kct_pkg::ST_UPD) && (req_type_r == kct_pkg::REQ_INC) &&
                   !any_hit && (|free_vec);
  assign ins_vec = do_ins ? (free_vec & ~(free_vec - N'(1))) : '0;

  assign cmd.rotate = (state_r == kct_pkg::ST_MAX) || (state_r == kct_pkg::ST_SCAN);
  assign cmd.inc    = (state_r == kct_pkg::ST_UPD) && (req_type_r == kct_pkg::REQ_INC);
  assign cmd.dec    = (state_r == kct_pkg::ST_UPD) && (req_type_r == kct_pkg::REQ_DEC);
  assign cmd.id     = req_id_r;

  // ring of cells, each takes its upper neighbor on rotate
  for (genvar i = 0; i < N; i++) begin : g_cell
    kct_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .ins_en  (ins_vec[i]),
      .nb_slot (slots[(i + 1) % N]),
      .slot    (slots[i]),
      .hit     (hit_vec[i])
    );
    assign free_vec[i] = !slots[i].valid;
  end

  assign cand = scan.valid && (scan.count == best_r) && (scan.id > prev_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kct_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.req_type == kct_pkg::REQ_QUERY) begin
            state_nxt = kct_pkg::ST_MAX;
          end else if ((in_ch.req_type == kct_pkg::REQ_INC ||
                        in_ch.req_type == kct_pkg::REQ_DEC) &&
                       (in_ch.content_id != '0)) begin
            state_nxt = kct_pkg::ST_UPD;
          end
        end
      end
      kct_pkg::ST_UPD: state_nxt = kct_pkg::ST_IDLE;
      kct_pkg::ST_MAX: begin
        if (pass_end) begin
          state_nxt = any_nxt ? kct_pkg::ST_SCAN : kct_pkg::ST_EMIT;
        end
      end
      kct_pkg::ST_SCAN: begin
        if (pass_end) state_nxt = kct_pkg::ST_EMIT;
      end
      kct_pkg::ST_EMIT: begin
        if (out_ch.ready) state_nxt = o_last_r ? kct_pkg::ST_IDLE : kct_pkg::ST_SCAN;
      end
      default: state_nxt = kct_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    req_type_nxt = req_type_r;
    req_id_nxt   = req_id_r;
    step_nxt     = step_r;
    best_nxt     = best_r;
    any_nxt      = any_r;
    prev_nxt     = prev_r;
    next_nxt     = next_r;
    got_nxt      = got_r;
    more_nxt     = more_r;
    dropped_nxt  = dropped_r;
    o_id_nxt     = o_id_r;
    o_count_nxt  = o_count_r;
    o_empty_nxt  = o_empty_r;
    o_last_nxt   = o_last_r;
    case (state_r)
      kct_pkg::ST_IDLE: begin
        req_type_nxt = in_ch.req_type;
        req_id_nxt   = in_ch.content_id;
        step_nxt     = '0;
        any_nxt      = 1'b0;
        best_nxt     = '0;
        prev_nxt     = '0;
        got_nxt      = 1'b0;
        more_nxt     = 1'b0;
      end
      kct_pkg::ST_UPD: begin
        if (cmd.inc && !any_hit && !(|free_vec)) dropped_nxt = 1'b1;
      end
      kct_pkg::ST_MAX: begin
        if (scan.valid) begin
          if (!any_r || scan.count > best_r) best_nxt = scan.count;
          any_nxt = 1'b1;
        end
        step_nxt = pass_end ? '0 : step_r + kct_pkg::IDX_W'(1);
        if (pass_end && !any_nxt) begin
          o_id_nxt    = '0;
          o_count_nxt = '0;
          o_empty_nxt = 1'b1;
          o_last_nxt  = 1'b1;
        end
      end
      kct_pkg::ST_SCAN: begin
        if (cand) begin
          if (!got_r || scan.id < next_r) begin
            if (got_r) more_nxt = 1'b1;
            next_nxt = scan.id;
          end else begin
            more_nxt = 1'b1;
          end
          got_nxt = 1'b1;
        end
        step_nxt = pass_end ? '0 : step_r + kct_pkg::IDX_W'(1);
        if (pass_end) begin
          o_id_nxt    = next_nxt;
          o_count_nxt = best_r;
          o_empty_nxt = 1'b0;
          o_last_nxt  = !more_nxt;
          prev_nxt    = next_nxt;
        end
      end
      kct_pkg::ST_EMIT: begin
        got_nxt  = 1'b0;
        more_nxt = 1'b0;
        step_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= kct_pkg::ST_IDLE;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_type_r <= req_type_nxt;
    req_id_r   <= req_id_nxt;
    step_r     <= step_nxt;
    best_r     <= best_nxt;
    any_r      <= any_nxt;
    prev_r     <= prev_nxt;
    next_r     <= next_nxt;
    got_r      <= got_nxt;
    more_r     <= more_nxt;
    o_id_r     <= o_id_nxt;
    o_count_r  <= o_count_nxt;
    o_empty_r  <= o_empty_nxt;
    o_last_r   <= o_last_nxt;
  end

  // drive the channels
  assign in_ch.ready          = (state_r == kct_pkg::ST_IDLE);
  assign out_ch.valid         = (state_r == kct_pkg::ST_EMIT);
  assign out_ch.top_id        = o_id_r;
  assign out_ch.top_count     = kct_pkg::OUT_CNT_BITS'(o_count_r);
  assign out_ch.table_empty   = o_empty_r;
  assign out_ch.overflow_seen = dropped_r;
  assign out_ch.last          = o_last_r;

`ifndef SYNTHESIS
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(hit_vec))
    else $error("more than one cell holds the same id");
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("request taken while a result is pending");
  a_sticky_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $past(dropped_r) |-> dropped_r)
    else $error("overflow flag cleared without reset");
  a_ins_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(ins_vec))
    else $error("insert into more than one cell");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import kct_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int DRAIN_CYCLES = 3 * TABLE_ENTRIES;
  localparam logic [ID_BITS-1:0] ID_TOP = {ID_BITS{1'b1}};

  typedef struct packed {
    logic [ID_BITS-1:0]      id;
    logic [OUT_CNT_BITS-1:0] cnt;
    logic                    empty;
    logic                    ovf;
    logic                    last;
  } top_result_t;

  // Tracks the counter table and the query results still owed by the block
  class top_id_scoreboard;
    bit                  used[TABLE_ENTRIES];
    bit [ID_BITS-1:0]    ids[TABLE_ENTRIES];
    bit [COUNT_BITS-1:0] cnts[TABLE_ENTRIES];
    bit                  dropped;
    top_result_t         pending[$];
    int                  mismatches;

    function int lookup(bit [ID_BITS-1:0] id);
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (used[i] && ids[i] == id) return i;
      return -1;
    endfunction

    // Apply one accepted request; a query queues its results
    function void note_request(logic [REQ_BITS-1:0] req, logic [ID_BITS-1:0] id);
      int s;
      bit found;
      bit [COUNT_BITS-1:0] peak;
      bit [ID_BITS-1:0] floor_id, pick;
      int n, k;
      top_result_t r;
      s = -1;
      found = 0;
      peak = '0;
      floor_id = '0;
      n = 0;
      if (req == REQ_INC && id != 0) begin
        s = lookup(id);
        if (s >= 0) begin
          if (cnts[s] != COUNT_MAX) cnts[s]++;
        end else begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!used[i]) begin
              used[i] = 1; ids[i] = id; cnts[i] = COUNT_BITS'(1); s = i;
              break;
            end
          end
          if (s < 0) dropped = 1;
        end
      end else if (req == REQ_DEC && id != 0) begin
        s = lookup(id);
        if (s >= 0) begin
          if (cnts[s] <= 1) used[s] = 0;
          else cnts[s]--;
        end
      end else if (req == REQ_QUERY) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (used[i] && (!found || cnts[i] > peak)) peak = cnts[i];
          if (used[i]) found = 1;
        end
        if (!found) begin
          r = '{id: '0, cnt: '0, empty: 1'b1, ovf: dropped, last: 1'b1};
          pending.push_back(r);
        end else begin
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (used[i] && cnts[i] == peak) n++;
          // emit tied ids smallest first
          for (k = 0; k < n; k++) begin
            pick = ID_TOP;
            for (int i = 0; i < TABLE_ENTRIES; i++)
              if (used[i] && cnts[i] == peak && ids[i] > floor_id && ids[i] <= pick)
                pick = ids[i];
            r = '{id: pick, cnt: peak, empty: 1'b0, ovf: dropped, last: (k == n - 1)};
            pending.push_back(r);
            floor_id = pick;
          end
        end
      end
    endfunction

    // Compare one accepted result with the oldest one owed
    function void check_result(top_result_t got);
      top_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result id=%0d cnt=%0d empty=%0b ovf=%0b last=%0b",
                   got.id, got.cnt, got.empty, got.ovf, got.last);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: exp id=%0d cnt=%0d empty=%0b ovf=%0b last=%0b / %s",
                   want.id, want.cnt, want.empty, want.ovf, want.last,
                   $sformatf("got id=%0d cnt=%0d empty=%0b ovf=%0b last=%0b",
                             got.id, got.cnt, got.empty, got.ovf, got.last));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  kct_in_if  in_ch();
  kct_out_if out_ch();

  keyed_counter_table_max_ties_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  top_id_scoreboard sb;
  int  burst_left;
  bit  long_hold;
  int  cycles;
  logic [ID_BITS-1:0] wide_ids[6];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Note accepted requests and check accepted results
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_request(in_ch.req_type, in_ch.content_id);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{id: out_ch.top_id, cnt: out_ch.top_count,
                        empty: out_ch.table_empty, ovf: out_ch.overflow_seen,
                        last: out_ch.last});
  end

  // Stall the result side on its own pattern, with one long hold-off
  initial begin
    int phase;
    out_ch.ready = 1'b0;
    phase = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 0;
      end
      phase++;
      if (phase % 600 < 150) out_ch.ready = 1'b1;
      else out_ch.ready = ($urandom_range(0, 3) != 0);
    end
  end

  // Timeout watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Offer one request and hold it until accepted; bursts end with a random gap
  task automatic send_req(logic [REQ_BITS-1:0] req, logic [ID_BITS-1:0] id);
    in_ch.valid = 1'b1;
    in_ch.req_type = req;
    in_ch.content_id = id;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
    end
  endtask

  // Draw an id: mostly a small pool for ties, some wide and random ids
  function automatic logic [ID_BITS-1:0] draw_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return ID_BITS'($urandom_range(1, 10));
    if (r < 88) return wide_ids[$urandom_range(0, 5)];
    if (r < 97) return ID_BITS'($urandom) & ID_TOP;
    return '0;
  endfunction

  task automatic random_reqs(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) send_req(REQ_INC, draw_id());
      else if (r < 80) send_req(REQ_DEC, draw_id());
      else if (r < 95) send_req(REQ_QUERY, ID_BITS'($urandom) & ID_TOP);
      else send_req(REQ_RSVD, draw_id());
    end
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    sb = new();
    long_hold = 0;
    burst_left = 0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_INC;
    in_ch.content_id = '0;
    foreach (wide_ids[i]) wide_ids[i] = (ID_BITS'($urandom) & ID_TOP) | ID_BITS'(1);
    wide_ids[0] = ID_TOP;
    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty query, extreme ids, ignored requests, ties, removal
    send_req(REQ_QUERY, '0);
    send_req(REQ_INC, ID_TOP);
    send_req(REQ_INC, 31'd1);
    send_req(REQ_INC, '0);
    send_req(REQ_DEC, '0);
    send_req(REQ_DEC, 31'd77);
    send_req(REQ_RSVD, 31'd1);
    send_req(REQ_QUERY, ID_TOP);
    send_req(REQ_INC, 31'd1);
    send_req(REQ_QUERY, '0);
    send_req(REQ_INC, ID_TOP);
    send_req(REQ_INC, 31'd5);
    send_req(REQ_INC, 31'd5);
    send_req(REQ_QUERY, '0);
    send_req(REQ_DEC, 31'd1);
    send_req(REQ_DEC, 31'd1);
    send_req(REQ_DEC, ID_TOP);
    send_req(REQ_DEC, ID_TOP);
    send_req(REQ_DEC, 31'd5);
    send_req(REQ_DEC, 31'd5);
    send_req(REQ_QUERY, '0);

    random_reqs(150);

    // Fill the table past capacity so inserts drop; query under a long stall
    for (int i = 0; i < 70; i++) send_req(REQ_INC, ID_BITS'($urandom_range(1000, 1000000)));
    long_hold = 1;
    send_req(REQ_QUERY, '0);
    for (int i = 0; i < 10; i++) send_req(REQ_INC, draw_id());
    send_req(REQ_QUERY, '0);

    random_reqs(170);
    drain();

    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Results still owed at the end are failures
  always @(negedge clk) begin
    if (cycles > CYCLE_LIMIT - 1 && sb.pending.size() != 0) sb.mismatches++;
  end

endmodule
